// File: hdl/bafc_pkg.sv
// Package for the bitmap next-fit chunk allocator.
// Holds the sizing constants, request codes and sequencer state type.
// No dependencies; used by the top level and the checker.
package bafc_pkg;

    // Pool geometry.
    localparam int NUM_CHUNKS  = 1024;
    localparam int CHUNK_BYTES = 16;
    localparam int MAP_BYTES   = NUM_CHUNKS / 8;

    localparam int CHUNK_W = $clog2(NUM_CHUNKS);   // chunk index
    localparam int BYTE_W  = $clog2(MAP_BYTES);    // bitmap byte address
    localparam int POOL_W  = CHUNK_W + 1;          // pool size register
    localparam int UNIT_W  = POOL_W - 3;           // pool size in bytes of the map

    // Request field widths.
    localparam int BYTES_W = 15;
    localparam int TYPE_W  = 2;
    // Chunks for the largest request plus the guard chunk.
    localparam int NEED_W  =
        $clog2(((2 ** BYTES_W) - 1 + CHUNK_BYTES - 1) / CHUNK_BYTES + 2);

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_POOL_CHUNKS = 1'b0;     // word index of pool_chunks
    localparam logic [POOL_W-1:0] POOL_RESET = POOL_W'(NUM_CHUNKS);

    // Stream widths.
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 16;

    typedef enum logic [TYPE_W-1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req_type;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WR,
        ST_DONE
    } t_state;

endpackage

// File: hdl/bitmap_next_fit_chunk_allocator.sv
// Top level of the bitmap next-fit chunk allocator.
// Contains the request sequencer, the occupancy bitmap memory and the config port.
// Depends on bafc_pkg.
//
// Usage:
//   Requests arrive on the slave stream. tuser carries the request type
//   (allocate, free, clear); tdata carries the byte size and, for a free, the
//   first data chunk. Every request yields exactly one word on the master
//   stream: tuser holds the ok flag and tdata the first data chunk of a new
//   allocation (zero otherwise).
//   The block takes one request at a time. An allocate reads the bitmap one
//   byte (eight chunks) per cycle starting at the next-fit cursor, wrapping
//   at the pool end and giving up back at the cursor, then rewrites each
//   bitmap byte touched by the new run to mark it. A free rewrites each
//   bitmap byte of the region within the pool. Clear and rejected requests
//   go straight to the result. The single bitmap read port and the byte-wide
//   scan step set this pace.
//   The result sits in an output register, so a new request is taken while
//   the previous result still waits; if the receiver stalls, the block holds
//   the next result internally and stops taking requests until the output
//   register drains.
//   Reset (synchronous, active low) empties the bitmap at once through
//   per-byte valid bits, sets the cursor to zero and pool_chunks to 1024.
//   pool_chunks sits at byte address 0 of the APB port and may be written
//   only while the block is idle.

module bitmap_next_fit_chunk_allocator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Request stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [14:0] request_bytes, [24:15] chunk_start, [31:25] zero
    input  logic [bafc_pkg::S_DATA_W-1:0]       i_s_axis_tdata,
    // [1:0] req_type
    input  logic [bafc_pkg::TYPE_W-1:0]         i_s_axis_tuser,
    // Result stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [9:0] chunk_index, [15:10] zero
    output logic [bafc_pkg::M_DATA_W-1:0]       o_m_axis_tdata,
    // [0] ok
    output logic                                o_m_axis_tuser,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bafc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [bafc_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [bafc_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int CW = bafc_pkg::CHUNK_W;
    localparam int BW = bafc_pkg::BYTE_W;
    localparam int NW = bafc_pkg::NEED_W;

    // Sequencer state.
    bafc_pkg::t_state           r_state, n_state;
    logic [CW-1:0]              r_sc, n_sc;         // next-fit cursor
    logic [CW-1:0]              r_cur, n_cur;       // scan position
    logic [NW-1:0]              r_got, n_got;       // free chunks in current run
    logic [CW-1:0]              r_cand, n_cand;     // start of current run
    logic [NW-1:0]              r_need, n_need;     // chunks wanted incl. guard
    logic [BW-1:0]              r_wb, n_wb;         // byte under update
    logic [CW-1:0]              r_ws, n_ws;         // first chunk of update range
    logic [CW-1:0]              r_wlast, n_wlast;   // last chunk of update range
    logic                       r_wset, n_wset;     // 1 marks used, 0 frees
    logic                       r_res_ok, n_res_ok;
    logic [CW-1:0]              r_res_idx, n_res_idx;

    // Output register.
    logic                       r_m_valid, n_m_valid;
    logic                       r_m_ok, n_m_ok;
    logic [CW-1:0]              r_m_idx, n_m_idx;

    // Configuration.
    logic [bafc_pkg::POOL_W-1:0] r_pool;

    // Bitmap memory and its per-byte valid bits.
    logic [7:0]                 r_map [bafc_pkg::MAP_BYTES];
    logic [bafc_pkg::MAP_BYTES-1:0] r_vld;
    logic [7:0]                 r_rdata;
    logic                       r_rvld;
    logic [BW-1:0]              rd_addr;
    logic                       wr_en;
    logic [BW-1:0]              wr_addr;
    logic [7:0]                 wr_data;
    logic                       vld_clear;

    // Request fields.
    logic [bafc_pkg::TYPE_W-1:0]  in_type;
    logic [bafc_pkg::BYTES_W-1:0] in_bytes;
    logic [CW-1:0]                in_cstart;
    logic [bafc_pkg::BYTES_W:0]   in_round;
    logic [NW-1:0]                in_need;

    // Effective pool size.
    logic [bafc_pkg::UNIT_W-1:0]  pool_units;
    logic [bafc_pkg::POOL_W-1:0]  pool_size;
    logic [BW-1:0]                last_byte;
    logic                         cfg_wr;

    assign in_type   = i_s_axis_tuser;
    assign in_bytes  = i_s_axis_tdata[bafc_pkg::BYTES_W-1:0];
    assign in_cstart = i_s_axis_tdata[bafc_pkg::BYTES_W +: CW];
    assign in_round  = (bafc_pkg::BYTES_W+1)'(in_bytes)
                     + (bafc_pkg::BYTES_W+1)'(bafc_pkg::CHUNK_BYTES - 1);
    assign in_need   = NW'(in_round / bafc_pkg::CHUNK_BYTES) + NW'(1);

    // Pool size: rounded down to whole bitmap bytes, kept within 8..NUM_CHUNKS.
    always_comb begin
        pool_units = r_pool[bafc_pkg::POOL_W-1:3];
        if (pool_units == '0) begin
            pool_units = bafc_pkg::UNIT_W'(1);
        end else if (pool_units > bafc_pkg::UNIT_W'(bafc_pkg::MAP_BYTES)) begin
            pool_units = bafc_pkg::UNIT_W'(bafc_pkg::MAP_BYTES);
        end
    end
    assign pool_size = {pool_units, 3'b000};
    assign last_byte = BW'(pool_units - bafc_pkg::UNIT_W'(1));

    // APB port: zero-wait, one register.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[bafc_pkg::CFG_ADDR_W-1:2] == bafc_pkg::REG_POOL_CHUNKS)
                  ? bafc_pkg::CFG_DATA_W'(r_pool) : '0;

    assign o_s_axis_tready = (r_state == bafc_pkg::ST_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tuser  = r_m_ok;
    assign o_m_axis_tdata  = bafc_pkg::M_DATA_W'(r_m_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bafc_pkg::ST_IDLE;
            r_sc      <= '0;
            r_m_valid <= 1'b0;
            r_pool    <= bafc_pkg::POOL_RESET;
            r_vld     <= '0;
        end else begin
            r_state   <= n_state;
            r_sc      <= n_sc;
            r_m_valid <= n_m_valid;
            if (cfg_wr && paddr[bafc_pkg::CFG_ADDR_W-1:2] == bafc_pkg::REG_POOL_CHUNKS) begin
                r_pool <= pwdata[bafc_pkg::POOL_W-1:0];
            end
            if (vld_clear) begin
                r_vld <= '0;
            end else if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_got     <= n_got;
        r_cand    <= n_cand;
        r_need    <= n_need;
        r_wb      <= n_wb;
        r_ws      <= n_ws;
        r_wlast   <= n_wlast;
        r_wset    <= n_wset;
        r_res_ok  <= n_res_ok;
        r_res_idx <= n_res_idx;
        r_m_ok    <= n_m_ok;
        r_m_idx   <= n_m_idx;
    end

    // Bitmap memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map[wr_addr] <= wr_data;
        end
        r_rdata <= r_map[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_rvld <= r_vld[rd_addr];
    end

    always_comb begin
        logic [NW-1:0] v_got;
        logic [CW-1:0] v_cand;
        logic [CW-1:0] v_cur;
        logic [CW-1:0] v_chunk;
        logic [CW-1:0] v_nxt;
        logic          v_stop;
        logic          v_fail;
        logic          v_found;
        logic          v_wrap;
        logic [7:0]    v_byte;
        logic [7:0]    v_mask;
        logic [NW-1:0] v_end;
        logic [NW-1:0] v_s;
        logic [CW-1:0] v_sc;

        n_state   = r_state;
        n_sc      = r_sc;
        n_cur     = r_cur;
        n_got     = r_got;
        n_cand    = r_cand;
        n_need    = r_need;
        n_wb      = r_wb;
        n_ws      = r_ws;
        n_wlast   = r_wlast;
        n_wset    = r_wset;
        n_res_ok  = r_res_ok;
        n_res_idx = r_res_idx;
        n_m_ok    = r_m_ok;
        n_m_idx   = r_m_idx;
        n_m_valid = r_m_valid & ~i_m_axis_tready;

        rd_addr   = r_wb + BW'(1);
        wr_en     = 1'b0;
        wr_addr   = r_wb;
        wr_data   = '0;
        vld_clear = 1'b0;

        v_got   = r_got;
        v_cand  = r_cand;
        v_cur   = r_cur;
        v_chunk = '0;
        v_nxt   = '0;
        v_stop  = 1'b0;
        v_fail  = 1'b0;
        v_found = 1'b0;
        v_wrap  = 1'b0;
        v_byte  = r_rvld ? r_rdata : 8'h00;
        v_mask  = 8'hFF;
        v_end   = '0;
        v_s     = '0;
        v_sc    = '0;

        case (r_state)
            bafc_pkg::ST_IDLE: begin
                n_res_ok  = 1'b0;
                n_res_idx = '0;
                if (i_s_axis_tvalid) begin
                    n_state = bafc_pkg::ST_DONE;
                    case (in_type)
                        bafc_pkg::REQ_ALLOC: begin
                            if (in_bytes != '0) begin
                                // A cursor left outside a shrunken pool restarts at zero.
                                v_sc    = ({1'b0, r_sc} >= pool_size) ? '0 : r_sc;
                                n_sc    = v_sc;
                                n_cur   = v_sc;
                                n_cand  = v_sc;
                                n_got   = '0;
                                n_need  = in_need;
                                rd_addr = v_sc[CW-1:3];
                                n_state = bafc_pkg::ST_SCAN;
                            end
                        end
                        bafc_pkg::REQ_FREE: begin
                            if (in_cstart != '0 && in_bytes != '0) begin
                                n_res_ok = 1'b1;
                                v_s      = NW'(in_cstart) - NW'(1);
                                v_end    = v_s + in_need;
                                if (v_end > NW'(pool_size)) begin
                                    v_end = NW'(pool_size);
                                end
                                // Regions starting beyond the pool touch nothing.
                                if (v_s < NW'(pool_size)) begin
                                    n_ws    = v_s[CW-1:0];
                                    n_wlast = CW'(v_end - NW'(1));
                                    n_wset  = 1'b0;
                                    n_wb    = v_s[CW-1:3];
                                    rd_addr = v_s[CW-1:3];
                                    n_state = bafc_pkg::ST_WR;
                                end
                            end
                        end
                        bafc_pkg::REQ_CLEAR: begin
                            vld_clear = 1'b1;
                            n_res_ok  = 1'b1;
                        end
                        default: begin
                            n_res_ok = 1'b0;
                        end
                    endcase
                end
            end

            bafc_pkg::ST_SCAN: begin
                // Walk the chunks of one bitmap byte, from the scan position to its end.
                for (int j = 0; j < 8; j++) begin
                    if (!v_stop && (3'(j) >= r_cur[2:0])) begin
                        v_chunk = {r_cur[CW-1:3], 3'(j)};
                        v_wrap  = (j == 7) && (r_cur[CW-1:3] == last_byte);
                        v_nxt   = v_wrap ? '0 : v_chunk + CW'(1);
                        if (v_byte[j]) begin
                            v_got  = '0;
                            v_cand = v_chunk + CW'(1);
                        end else begin
                            v_got = v_got + NW'(1);
                        end
                        // A partial run cut by the pool end is dropped.
                        if (v_wrap && v_got < r_need) begin
                            v_cand = '0;
                            v_got  = '0;
                        end
                        v_cur = v_nxt;
                        if (v_nxt == r_sc) begin
                            v_stop = 1'b1;
                            v_fail = 1'b1;
                        end else if (v_got >= r_need) begin
                            v_stop  = 1'b1;
                            v_found = 1'b1;
                        end
                    end
                end
                if (v_fail) begin
                    n_res_ok  = 1'b0;
                    n_res_idx = '0;
                    n_state   = bafc_pkg::ST_DONE;
                end else if (v_found) begin
                    n_sc      = v_cur;
                    n_ws      = v_cand;
                    n_wlast   = CW'(NW'(v_cand) + r_need - NW'(1));
                    n_wset    = 1'b1;
                    n_wb      = v_cand[CW-1:3];
                    rd_addr   = v_cand[CW-1:3];
                    n_res_ok  = 1'b1;
                    n_res_idx = v_cand + CW'(1);
                    n_state   = bafc_pkg::ST_WR;
                end else begin
                    n_cur   = v_cur;
                    n_got   = v_got;
                    n_cand  = v_cand;
                    rd_addr = v_cur[CW-1:3];
                end
            end

            bafc_pkg::ST_WR: begin
                // Read-modify-write of one bitmap byte per cycle.
                if (r_wb == r_ws[CW-1:3]) begin
                    v_mask = v_mask & (8'hFF << r_ws[2:0]);
                end
                if (r_wb == r_wlast[CW-1:3]) begin
                    v_mask = v_mask & (8'hFF >> (3'd7 - r_wlast[2:0]));
                end
                wr_en   = 1'b1;
                wr_addr = r_wb;
                wr_data = r_wset ? (v_byte | v_mask) : (v_byte & ~v_mask);
                if (r_wb == r_wlast[CW-1:3]) begin
                    n_state = bafc_pkg::ST_DONE;
                end else begin
                    n_wb    = r_wb + BW'(1);
                    rd_addr = r_wb + BW'(1);
                end
            end

            bafc_pkg::ST_DONE: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_ok    = r_res_ok;
                    n_m_idx   = r_res_idx;
                    n_state   = bafc_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = bafc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/bafc_checker.sv
// Port-level checker for the bitmap next-fit chunk allocator.
// Watches only the top level's ports and is bound to it below.
// Depends on bafc_pkg.
module bafc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [bafc_pkg::M_DATA_W-1:0]    o_m_axis_tdata,
    input logic                             o_m_axis_tuser,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic [bafc_pkg::CFG_ADDR_W-1:0]  paddr,
    input logic [bafc_pkg::CFG_DATA_W-1:0]  pwdata,
    input logic [bafc_pkg::CFG_DATA_W-1:0]  prdata,
    input logic                             pready
);

    // A pending result word stays up until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result word dropped while stalled");

    // One request at a time: the block is busy right after taking a word.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("request taken while previous one in progress");

    // A failed answer, with ok low, never carries a chunk index.
    a_fail_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |->
            o_m_axis_tdata[bafc_pkg::CHUNK_W-1:0] == '0)
        else $error("failed request returned a nonzero chunk index");

    // The upper bits of the result word are padding.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            o_m_axis_tdata[bafc_pkg::M_DATA_W-1:bafc_pkg::CHUNK_W] == '0)
        else $error("result padding bits set");

    // Reading back the pool register after a write returns the written value.
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready
            && paddr[bafc_pkg::CFG_ADDR_W-1:2] == bafc_pkg::REG_POOL_CHUNKS
            ##1 !pwrite && paddr[bafc_pkg::CFG_ADDR_W-1:2] == bafc_pkg::REG_POOL_CHUNKS
        |-> prdata == bafc_pkg::CFG_DATA_W'($past(pwdata[bafc_pkg::POOL_W-1:0])))
        else $error("pool_chunks readback mismatch");

endmodule

bind bitmap_next_fit_chunk_allocator bafc_checker u_bafc_checker (.*);

// File: dv/bitmap_next_fit_chunk_allocator_tb.sv
// Self-checking testbench for the bitmap next-fit chunk allocator.
// Drives request words, programs pool_chunks over APB and checks every result word against
// a behavioral predictor in this file or a hand-typed result. Depends on bafc_pkg and the RTL top.
`timescale 1ns / 100ps

module bitmap_next_fit_chunk_allocator_tb;

    // A two-bit request code that the block does not know; it must be ignored.
    localparam logic [bafc_pkg::TYPE_W-1:0] REQ_UNKNOWN = 2'd3;
    // Byte address of pool_chunks on the APB port.
    localparam logic [bafc_pkg::CFG_ADDR_W-1:0] POOL_ADDR =
        bafc_pkg::CFG_ADDR_W'(int'(bafc_pkg::REG_POOL_CHUNKS) * 4);
    localparam int MAX_BYTES     = (2 ** bafc_pkg::BYTES_W) - 1;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 93;
    localparam int DRAIN_CYCLES  = 300;    // longer than a full scan plus the run marking

    // One result word: the ok flag and the first data chunk.
    typedef struct packed {
        logic                         ok;
        logic [bafc_pkg::CHUNK_W-1:0] idx;
    } t_reply;

    // One row of the directed table. When typed is set, reply holds the result
    // written in by hand; otherwise the predictor supplies it.
    typedef struct packed {
        logic [bafc_pkg::TYPE_W-1:0]  kind;
        logic [bafc_pkg::BYTES_W-1:0] bytes;
        logic [bafc_pkg::CHUNK_W-1:0] cstart;
        logic                         typed;
        t_reply                       reply;
    } t_vector;

    // A region handed out by the block and not yet given back.
    typedef struct packed {
        logic [bafc_pkg::CHUNK_W-1:0] chunk;
        logic [bafc_pkg::BYTES_W-1:0] bytes;
    } t_region;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_s_axis_tvalid = 1'b0;
    logic                               o_s_axis_tready;
    logic [bafc_pkg::S_DATA_W-1:0]      i_s_axis_tdata = '0;
    logic [bafc_pkg::TYPE_W-1:0]        i_s_axis_tuser = '0;
    logic                               o_m_axis_tvalid;
    logic                               i_m_axis_tready = 1'b0;
    logic [bafc_pkg::M_DATA_W-1:0]      o_m_axis_tdata;
    logic                               o_m_axis_tuser;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [bafc_pkg::CFG_ADDR_W-1:0]    paddr = '0;
    logic [bafc_pkg::CFG_DATA_W-1:0]    pwdata = '0;
    logic [bafc_pkg::CFG_DATA_W-1:0]    prdata;
    logic                               pready;

    bitmap_next_fit_chunk_allocator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Predictor state: the occupancy bitmap, the next-fit cursor and the raw
    // pool_chunks register, all as the block holds them after reset.
    logic [bafc_pkg::NUM_CHUNKS-1:0]  occ_bits = '0;
    int                               next_fit_pos = 0;
    logic [bafc_pkg::POOL_W-1:0]      pool_reg = bafc_pkg::POOL_RESET;

    t_reply                 pending_replies[$];
    t_vector                directed_rows[$];
    t_region                live_regions[$];

    bit                     no_gaps = 1'b0;
    int                     stall_left = 0;
    int                     n_errors = 0;
    int                     n_words = 0;
    int                     n_alloc_ok = 0;
    int                     n_alloc_refused = 0;
    int                     n_frees = 0;
    int                     n_clears = 0;
    int                     n_ignored = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs; the limit leaves plenty of margin over the slowest legal run.
    initial begin
        #50_000_000;
        $display("%0t: timeout, %0d result words still outstanding", $time,
                 pending_replies.size());
        $display("status: fail");
        $finish;
    end

    // Gap lengths: mostly none or short, now and then a long one. A phase may
    // switch gaps off entirely so back-to-back traffic is covered too.
    function automatic int rand_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 150);
    endfunction

    // Effective pool size: the register rounded down to a multiple of eight,
    // then clamped to 8..NUM_CHUNKS.
    function automatic int pool_limit();
        int p;
        p = int'(pool_reg) & ~7;
        if (p < 8) p = 8;
        if (p > bafc_pkg::NUM_CHUNKS) p = bafc_pkg::NUM_CHUNKS;
        return p;
    endfunction

    function automatic int chunks_for(logic [bafc_pkg::BYTES_W-1:0] bytes);
        return (int'(bytes) + bafc_pkg::CHUNK_BYTES - 1) / bafc_pkg::CHUNK_BYTES;
    endfunction

    // Computes the result of one accepted request and updates the predictor
    // state the way the block must.
    function automatic t_reply predict_reply(logic [bafc_pkg::TYPE_W-1:0] kind,
                                             logic [bafc_pkg::BYTES_W-1:0] bytes,
                                             logic [bafc_pkg::CHUNK_W-1:0] cstart);
        t_reply r;
        int     p;
        int     need;
        int     got;
        int     cand;
        int     cur;
        int     first;
        int     i;
        bit     gave_up;
        r = '0;
        p = pool_limit();
        case (kind)
            bafc_pkg::REQ_ALLOC: begin
                if (bytes != 0) begin
                    need = chunks_for(bytes) + 1;
                    // A cursor left outside a shrunken pool restarts at zero.
                    if (next_fit_pos >= p) next_fit_pos = 0;
                    got = 0;
                    cand = next_fit_pos;
                    cur = next_fit_pos;
                    gave_up = 1'b0;
                    // Walk forward one chunk at a time. A run cut by the pool
                    // end is dropped, and getting back to the cursor is a miss
                    // even when a run would close exactly there.
                    do begin
                        if (!occ_bits[cur]) begin
                            got++;
                        end else begin
                            got = 0;
                            cand = cur + 1;
                        end
                        cur++;
                        if (cur >= p) begin
                            cur = 0;
                            if (got < need) begin
                                cand = 0;
                                got = 0;
                            end
                        end
                        if (cur == next_fit_pos) gave_up = 1'b1;
                    end while (!gave_up && got < need);
                    if (!gave_up) begin
                        next_fit_pos = cur;
                        for (i = 0; i < need; i++) occ_bits[cand + i] = 1'b1;
                        r.ok = 1'b1;
                        r.idx = bafc_pkg::CHUNK_W'(cand + 1);
                    end
                end
            end
            bafc_pkg::REQ_FREE: begin
                // Chunk zero or zero bytes name no region. Chunks at or past
                // the pool end are never touched.
                if (cstart != 0 && bytes != 0) begin
                    first = int'(cstart) - 1;
                    need = chunks_for(bytes) + 1;
                    for (i = 0; i < need && first + i < p; i++) occ_bits[first + i] = 1'b0;
                    r.ok = 1'b1;
                end
            end
            bafc_pkg::REQ_CLEAR: begin
                occ_bits = '0;
                r.ok = 1'b1;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic void add_row(logic [bafc_pkg::TYPE_W-1:0] kind, int bytes,
                                    int cstart, logic typed, logic ok, int idx);
        t_vector v;
        v.kind = kind;
        v.bytes = bafc_pkg::BYTES_W'(bytes);
        v.cstart = bafc_pkg::CHUNK_W'(cstart);
        v.typed = typed;
        v.reply.ok = ok;
        v.reply.idx = bafc_pkg::CHUNK_W'(idx);
        directed_rows.push_back(v);
    endfunction

    // Presents one request word, waits for the handshake, then records the
    // expected result. tdata: [14:0] request_bytes, [24:15] chunk_start.
    task automatic issue_request(logic [bafc_pkg::TYPE_W-1:0] kind,
                                 logic [bafc_pkg::BYTES_W-1:0] bytes,
                                 logic [bafc_pkg::CHUNK_W-1:0] cstart, logic typed,
                                 t_reply typed_reply);
        int     gap;
        t_reply predicted;
        @(negedge i_clk);
        gap = rand_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= kind;
        i_s_axis_tdata <= bafc_pkg::S_DATA_W'({cstart, bytes});
        do @(posedge i_clk); while (!o_s_axis_tready);

        predicted = predict_reply(kind, bytes, cstart);
        pending_replies.push_back(typed ? typed_reply : predicted);

        // Keep track of live regions so later frees can return them intact.
        case (kind)
            bafc_pkg::REQ_ALLOC: begin
                if (predicted.ok) begin
                    live_regions.push_back('{predicted.idx, bytes});
                    n_alloc_ok++;
                end else begin
                    n_alloc_refused++;
                end
            end
            bafc_pkg::REQ_FREE:  n_frees++;
            bafc_pkg::REQ_CLEAR: begin
                live_regions.delete();
                n_clears++;
            end
            default:   n_ignored++;
        endcase
    endtask

    // Lowers the request valid and waits until every expected word is back,
    // plus a few cycles so the block has settled into idle.
    task automatic wait_idle();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes pool_chunks (setup then access cycle) and reads it back.
    task automatic program_pool(logic [bafc_pkg::POOL_W-1:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= POOL_ADDR;
        pwdata <= bafc_pkg::CFG_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        pool_reg = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== bafc_pkg::CFG_DATA_W'(value)) begin
            $display("%0t: pool_chunks readback expected %0d, got %0d",
                     $time, value, prdata);
            n_errors++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random traffic for one pool setting. Most requests are allocations and
    // frees of regions that are really live, so the bitmap fills, fragments
    // and drains; the rest is noise: stray frees, null frees, clears,
    // zero-byte allocations and unknown request codes.
    task automatic run_random_phase(int count);
        int                             n;
        int                             pick;
        int                             sz;
        int                             j;
        logic [bafc_pkg::TYPE_W-1:0]    kind;
        logic [bafc_pkg::BYTES_W-1:0]   bytes;
        logic [bafc_pkg::CHUNK_W-1:0]   cstart;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            kind = bafc_pkg::REQ_ALLOC;
            bytes = '0;
            cstart = bafc_pkg::CHUNK_W'($urandom_range(0, bafc_pkg::NUM_CHUNKS - 1));
            if (pick < 80) begin
                if (pick >= 45 && live_regions.size() != 0) begin
                    j = $urandom_range(0, live_regions.size() - 1);
                    kind = bafc_pkg::REQ_FREE;
                    bytes = live_regions[j].bytes;
                    cstart = live_regions[j].chunk;
                    live_regions.delete(j);
                end else begin
                    // Sizes mostly small, sometimes a good part of the pool,
                    // rarely anything the field can carry.
                    sz = $urandom_range(0, 9);
                    if (sz < 7)
                        bytes = bafc_pkg::BYTES_W'(
                            $urandom_range(1, 8 * bafc_pkg::CHUNK_BYTES));
                    else if (sz < 9)
                        bytes = bafc_pkg::BYTES_W'(
                            $urandom_range(1, pool_limit() * bafc_pkg::CHUNK_BYTES / 3));
                    else
                        bytes = bafc_pkg::BYTES_W'($urandom_range(1, MAX_BYTES));
                end
            end else if (pick < 88) begin
                kind = bafc_pkg::REQ_FREE;
                if ($urandom_range(0, 3) == 0)
                    bytes = bafc_pkg::BYTES_W'($urandom_range(0, MAX_BYTES));
                else
                    bytes = bafc_pkg::BYTES_W'($urandom_range(0, 255));
            end else if (pick < 91) begin
                kind = bafc_pkg::REQ_CLEAR;
                bytes = bafc_pkg::BYTES_W'($urandom_range(0, MAX_BYTES));
            end else if (pick < 94) begin
                kind = REQ_UNKNOWN;
                bytes = bafc_pkg::BYTES_W'($urandom_range(0, MAX_BYTES));
            end else if (pick < 97) begin
                kind = bafc_pkg::REQ_ALLOC;
            end else begin
                kind = bafc_pkg::REQ_FREE;
                cstart = '0;
                bytes = bafc_pkg::BYTES_W'($urandom_range(1, MAX_BYTES));
            end
            issue_request(kind, bytes, cstart, 1'b0, '0);
        end
    endtask

    // Result side: ready is dropped for random stretches, changed only at the
    // falling edge.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            i_m_axis_tready <= 1'b1;
            stall_left = rand_gap();
        end
    end

    // Every accepted result word is checked against the oldest expectation.
    // tdata: [9:0] chunk_index, upper bits zero. tuser: ok.
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            n_words++;
            if (pending_replies.size() == 0) begin
                $display("%0t: result word with nothing expected: ok=%0d index=%0d",
                         $time, o_m_axis_tuser, o_m_axis_tdata);
                n_errors++;
            end else begin
                want = pending_replies.pop_front();
                if (o_m_axis_tuser !== want.ok) begin
                    $display("%0t: ok expected %0d, got %0d", $time, want.ok, o_m_axis_tuser);
                    n_errors++;
                end
                if (o_m_axis_tdata !== bafc_pkg::M_DATA_W'(want.idx)) begin
                    $display("%0t: chunk_index expected %0d, got %0d",
                             $time, want.idx, o_m_axis_tdata);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        int                             ph;
        int                             k;
        logic [bafc_pkg::POOL_W-1:0]    setting;
        int                             fixed_pools[8];

        // Register settings per phase: clamp to the top, the smallest pool
        // (which also strands the cursor outside it), a value that rounds
        // down, the all-zero register, and a few ordinary sizes.
        fixed_pools = '{2047, 8, 1023, 0, 96, 1024, 7, 515};

        // Hold reset from the start, then release it at a falling edge.
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, run from the reset state with a 1024-chunk pool.
        // Columns: request, bytes, chunk_start, hand-typed, ok, chunk_index.
        add_row(bafc_pkg::REQ_ALLOC, 0,     0,     1'b1, 1'b0, 0); // zero-byte allocate refused
        add_row(bafc_pkg::REQ_ALLOC, 1,     0,     1'b1, 1'b1, 1); // guard at 0, data at 1
        add_row(bafc_pkg::REQ_ALLOC, 16,    0,     1'b0, 1'b0, 0); // exactly one chunk
        add_row(bafc_pkg::REQ_ALLOC, 17,    0,     1'b0, 1'b0, 0); // one byte over a chunk
        add_row(bafc_pkg::REQ_ALLOC, 16384, 0,     1'b1, 1'b0, 0); // larger than the pool
        add_row(bafc_pkg::REQ_ALLOC, 32767, 1023,  1'b1, 1'b0, 0); // all-ones size field
        add_row(bafc_pkg::REQ_FREE,  16,    0,     1'b1, 1'b0, 0); // free of chunk zero is null
        add_row(bafc_pkg::REQ_FREE,  0,     1,     1'b1, 1'b0, 0); // free of zero bytes is null
        add_row(bafc_pkg::REQ_FREE,  1,     1,     1'b1, 1'b1, 0); // return the first region
        add_row(bafc_pkg::REQ_FREE,  32767, 1023,  1'b1, 1'b1, 0); // runs past the pool end
        add_row(REQ_UNKNOWN,         32767, 1023,  1'b1, 1'b0, 0); // unknown code is ignored
        add_row(bafc_pkg::REQ_CLEAR, 0,     0,     1'b1, 1'b1, 0); // empty map, cursor kept
        add_row(bafc_pkg::REQ_ALLOC, 16368, 0,     1'b1, 1'b0, 0); // run spans the whole pool
        add_row(bafc_pkg::REQ_ALLOC, 16352, 0,     1'b0, 1'b0, 0); // one chunk short of it
        add_row(bafc_pkg::REQ_ALLOC, 16000, 0,     1'b0, 1'b0, 0); // nearly fills the pool
        add_row(bafc_pkg::REQ_ALLOC, 320,   0,     1'b0, 1'b0, 0); // no room left
        add_row(bafc_pkg::REQ_ALLOC, 224,   0,     1'b0, 1'b0, 0); // fits, one chunk short of the end
        add_row(bafc_pkg::REQ_ALLOC, 16,    0,     1'b0, 1'b0, 0); // partial run at end dropped
        add_row(bafc_pkg::REQ_FREE,  8,     16000, 1'b0, 1'b0, 0); // free by the predictor
        add_row(bafc_pkg::REQ_FREE,  16000, 8,     1'b1, 1'b1, 0); // return the big region
        add_row(bafc_pkg::REQ_CLEAR, 32767, 1023,  1'b1, 1'b1, 0); // clear with all-ones fields
        for (k = 0; k < directed_rows.size(); k++)
            issue_request(directed_rows[k].kind, directed_rows[k].bytes,
                          directed_rows[k].cstart, directed_rows[k].typed,
                          directed_rows[k].reply);

        // Random phases. Before each one the sender holds off until every
        // result is back, so the register write lands on an idle block.
        for (ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            setting = (ph < 8) ? bafc_pkg::POOL_W'(fixed_pools[ph])
                               : bafc_pkg::POOL_W'($urandom_range(0, 2047));
            program_pool(setting);
            no_gaps = ($urandom_range(0, 3) == 0);
            run_random_phase(PHASE_ITEMS);
        end

        no_gaps = 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d result words over %0d pool settings: %0d allocations granted,",
                 n_words, PHASES + 1, n_alloc_ok);
        $display("%0d refused, %0d frees, %0d clears, %0d ignored requests; %0d mismatches",
                 n_alloc_refused, n_frees, n_clears, n_ignored, n_errors);
        if (n_errors == 0 && pending_replies.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
